[sv/evhm_pkg.sv]
// Shared types and constants for the encoder velocity and health monitor.
// No dependencies; used by evhm_ctrl, evhm_dp and the top level.
`default_nettype none

package evhm_pkg;

  localparam int ANG_W  = 12;
  localparam int SB_W   = 8;
  localparam int TICK_W = 32;
  localparam int VEL_W  = 16;
  localparam int MINIV_W = 10;
  localparam int THR_W  = 15;
  localparam int CFGI_W = 2;
  localparam int CFGD_W = 15;

  // Elapsed time saturates at 2^19 - 1 ms.
  localparam int DT_W = 19;
  localparam logic [DT_W-1:0] DT_MAX = 19'd524287;

  // Numerator is |delta| * 60000: 12 bits times 16 bits.
  localparam int NUM_W = 28;
  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [NUM_W-1:0] RPM_SCALE = 28'd60000;
  localparam logic [THR_W-1:0] RPM_LIMIT = 15'd30000;

  // Poll outcome codes.
  localparam logic [1:0] OUTC_ANGLE_FAIL  = 2'd0;
  localparam logic [1:0] OUTC_STATUS_FAIL = 2'd1;
  localparam logic [1:0] OUTC_GOOD        = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic [CFGI_W-1:0] CFG_MIN_INTERVAL = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_SPIN_THRESH  = 2'd1;
  localparam logic [MINIV_W-1:0] MIN_INTERVAL_RST = 10'd10;
  localparam logic [THR_W-1:0]   SPIN_THRESH_RST  = 15'd100;

  // Status byte bit positions.
  localparam int SB_WEAK_BIT   = 3;
  localparam int SB_STRONG_BIT = 4;
  localparam int SB_MAGNET_BIT = 5;

  typedef struct packed {
    logic ready;
    logic hw_fault;
    logic missing;
    logic mag_low;
    logic mag_high;
    logic spin;
    logic fan_fault;
  } flags_t;

  typedef struct packed {
    logic capture;   // latch an input word
    logic prep;      // elapsed time, angle wrap, update decision
    logic mul;       // form numerator and denominator
    logic div_step;  // one restoring division step
    logic commit;    // update state and present the result word
  } cmd_t;

  typedef struct packed {
    logic go;        // velocity update due for the latched word
    logic div_last;  // final division step this cycle
    logic out_free;  // result register may be reloaded
  } sts_t;

endpackage

`default_nettype wire

[sv/evhm_ctrl.sv]
// Sequencing state machine for the encoder velocity and health monitor.
// Depends on evhm_pkg (cmd_t, sts_t).
`default_nettype none

module evhm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  evhm_pkg::sts_t     sts,
  output evhm_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.go ? ST_MUL : ST_FIN;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the result register is free
        cmd.commit = sts.out_free;
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free)
    else $error("commit issued while result register busy");
  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.prep)
    else $error("accepted word not followed by prep");
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && sts.div_last) |=> (state_r == ST_FIN))
    else $error("division end did not reach finish");
`endif

endmodule

`default_nettype wire

[sv/evhm_dp.sv]
// Datapath: input capture, angle wrap, multiply, serial divider, flags, config.
// Depends on evhm_pkg; driven by evhm_ctrl through cmd_t and sts_t.
`default_nettype none

module evhm_dp #(
  parameter int COUNTS_PER_REV = 4096
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  evhm_pkg::cmd_t                          cmd,
  output evhm_pkg::sts_t                          sts,
  input  wire logic [1:0]                         in_outcome,
  input  wire logic [evhm_pkg::ANG_W-1:0]         in_angle,
  input  wire logic [evhm_pkg::SB_W-1:0]          in_status_byte,
  input  wire logic [evhm_pkg::TICK_W-1:0]        in_now_ms,
  input  wire logic                               cfg_valid,
  input  wire logic [evhm_pkg::CFGI_W-1:0]        cfg_index,
  input  wire logic [evhm_pkg::CFGD_W-1:0]        cfg_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [evhm_pkg::VEL_W-1:0]       vel,
  output evhm_pkg::flags_t                        flags
);

  localparam int CPR_W = $clog2(COUNTS_PER_REV + 1);
  localparam int DEN_W = evhm_pkg::DT_W + CPR_W;
  localparam int SW    = ((CPR_W > evhm_pkg::ANG_W) ? CPR_W : evhm_pkg::ANG_W) + 2;
  localparam logic signed [SW-1:0] CPR_S  = SW'(COUNTS_PER_REV);
  localparam logic signed [SW-1:0] HALF_S = SW'(COUNTS_PER_REV / 2);
  localparam logic [DEN_W-1:0]     CPR_D  = DEN_W'(COUNTS_PER_REV);

  // captured word
  logic [1:0]                      outc_r;
  logic [evhm_pkg::ANG_W-1:0]      angle_r;
  logic [evhm_pkg::SB_W-1:0]       sb_r;
  logic [evhm_pkg::TICK_W-1:0]     now_r;

  // working registers
  logic                            go_r;
  logic [evhm_pkg::DT_W-1:0]       dt_r;
  logic [evhm_pkg::ANG_W-1:0]      mag_r;
  logic                            neg_r;
  logic [evhm_pkg::NUM_W-1:0]      num_r;
  logic [DEN_W-1:0]                den_r;
  logic [DEN_W-1:0]                rem_r;
  logic [evhm_pkg::NUM_W-1:0]      quo_r;
  logic [evhm_pkg::CNT_W-1:0]      cnt_r;

  // state and config
  logic [evhm_pkg::ANG_W-1:0]      prev_angle_r, prev_angle_nxt;
  logic [evhm_pkg::TICK_W-1:0]     prev_time_r, prev_time_nxt;
  logic signed [evhm_pkg::VEL_W-1:0] vel_r, vel_nxt;
  evhm_pkg::flags_t                flags_r, flags_nxt;
  logic [evhm_pkg::MINIV_W-1:0]    min_iv_r;
  logic [evhm_pkg::THR_W-1:0]      spin_thr_r;
  logic                            out_valid_r;

  // prep logic
  logic [evhm_pkg::TICK_W-1:0]     dt_raw;
  logic [evhm_pkg::DT_W-1:0]       dt_sat;
  logic [evhm_pkg::MINIV_W-1:0]    lim;
  logic                            go_c;
  logic signed [SW-1:0]            s0, s1, s2, s_abs;

  // divider step
  logic [DEN_W:0]                  trial;
  logic                            q_bit;

  // finish logic
  logic [evhm_pkg::THR_W-1:0]      q_sat;
  logic [evhm_pkg::VEL_W-1:0]      qv, vel_abs;

  always_comb begin
    dt_raw = now_r - prev_time_r;
    dt_sat = (dt_raw > evhm_pkg::TICK_W'(evhm_pkg::DT_MAX)) ?
             evhm_pkg::DT_MAX : dt_raw[evhm_pkg::DT_W-1:0];
    lim    = (min_iv_r == '0) ? evhm_pkg::MINIV_W'(1) : min_iv_r;
    go_c   = ((outc_r == evhm_pkg::OUTC_STATUS_FAIL) || (outc_r == evhm_pkg::OUTC_GOOD))
             && (dt_sat >= evhm_pkg::DT_W'(lim));

    s0    = $signed(SW'(angle_r)) - $signed(SW'(prev_angle_r));
    s1    = (s0 > HALF_S) ? (s0 - CPR_S) : s0;
    s2    = (s1 < -HALF_S) ? (s1 + CPR_S) : s1;
    s_abs = s2[SW-1] ? -s2 : s2;
  end

  assign trial = {rem_r, num_r[evhm_pkg::NUM_W-1]};
  assign q_bit = (trial >= {1'b0, den_r});

  always_comb begin
    q_sat   = (quo_r > evhm_pkg::NUM_W'(evhm_pkg::RPM_LIMIT)) ?
              evhm_pkg::RPM_LIMIT : quo_r[evhm_pkg::THR_W-1:0];
    qv      = {1'b0, q_sat};

    prev_angle_nxt = prev_angle_r;
    prev_time_nxt  = prev_time_r;
    vel_nxt        = vel_r;
    if (go_r) begin
      prev_angle_nxt = angle_r;
      prev_time_nxt  = now_r;
      vel_nxt        = $signed(neg_r ? (~qv + 1'b1) : qv);
    end
    vel_abs = vel_nxt[evhm_pkg::VEL_W-1] ? (~vel_nxt + 1'b1) : vel_nxt;

    flags_nxt = flags_r;
    case (outc_r)
      evhm_pkg::OUTC_ANGLE_FAIL, evhm_pkg::OUTC_STATUS_FAIL: begin
        flags_nxt.hw_fault  = 1'b1;
        flags_nxt.fan_fault = 1'b1;
      end
      evhm_pkg::OUTC_GOOD: begin
        flags_nxt.ready    = 1'b1;
        flags_nxt.hw_fault = 1'b0;
        flags_nxt.missing  = !sb_r[evhm_pkg::SB_MAGNET_BIT];
        flags_nxt.mag_low  = sb_r[evhm_pkg::SB_MAGNET_BIT] && sb_r[evhm_pkg::SB_WEAK_BIT];
        flags_nxt.mag_high = sb_r[evhm_pkg::SB_MAGNET_BIT] && !sb_r[evhm_pkg::SB_WEAK_BIT]
                             && sb_r[evhm_pkg::SB_STRONG_BIT];
        flags_nxt.spin     = vel_abs > {1'b0, spin_thr_r};
        flags_nxt.fan_fault = flags_nxt.missing || flags_nxt.mag_low || flags_nxt.mag_high;
      end
      default: flags_nxt = flags_r;
    endcase
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      outc_r  <= in_outcome;
      angle_r <= in_angle;
      sb_r    <= in_status_byte;
      now_r   <= in_now_ms;
    end
    if (cmd.prep) begin
      go_r  <= go_c;
      dt_r  <= dt_sat;
      neg_r <= s2[SW-1];
      mag_r <= s_abs[evhm_pkg::ANG_W-1:0];
    end
    if (cmd.mul) begin
      num_r <= evhm_pkg::NUM_W'(mag_r) * evhm_pkg::RPM_SCALE;
      den_r <= DEN_W'(dt_r) * CPR_D;
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo_r <= {quo_r[evhm_pkg::NUM_W-2:0], q_bit};
      num_r <= {num_r[evhm_pkg::NUM_W-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // state, configuration and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_angle_r <= '0;
      prev_time_r  <= '0;
      vel_r        <= '0;
      flags_r      <= '0;
      min_iv_r     <= evhm_pkg::MIN_INTERVAL_RST;
      spin_thr_r   <= evhm_pkg::SPIN_THRESH_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          evhm_pkg::CFG_MIN_INTERVAL: min_iv_r   <= cfg_data[evhm_pkg::MINIV_W-1:0];
          evhm_pkg::CFG_SPIN_THRESH:  spin_thr_r <= cfg_data[evhm_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        prev_angle_r <= prev_angle_nxt;
        prev_time_r  <= prev_time_nxt;
        vel_r        <= vel_nxt;
        flags_r      <= flags_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  assign sts.go       = go_c;
  assign sts.div_last = (cnt_r == evhm_pkg::CNT_W'(evhm_pkg::NUM_W - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign vel       = vel_r;
  assign flags     = flags_r;

`ifndef SYNTHESIS
  a_vel_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vel_r <= 16'sd30000) && (vel_r >= -16'sd30000))
    else $error("velocity out of range");
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (den_r != '0))
    else $error("division by zero");
  a_mag_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({flags_r.missing, flags_r.mag_low, flags_r.mag_high}))
    else $error("more than one magnet flag");
  a_fan_good: assert property (@(posedge clk) disable iff (!rst_n)
    (flags_r.ready && !flags_r.hw_fault) |->
      (flags_r.fan_fault == (flags_r.missing || flags_r.mag_low || flags_r.mag_high)))
    else $error("fan fault disagrees with magnet flags");
`endif

endmodule

`default_nettype wire

[sv/encoder_velocity_and_health_monitor_core.sv]
// Encoder velocity and health monitor: top level joining controller and datapath.
// Depends on evhm_pkg, evhm_ctrl and evhm_dp.
//
// Usage:
//   Input channel (in_valid/in_ready): one word per finished sensor poll with
//   outcome code, 12-bit angle, status byte and millisecond tick.
//   Result channel (out_valid/out_ready): exactly one word per input word with
//   the current velocity and health flags.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 minimum
//   interval in ms, index 1 spin threshold in rpm; cfg_ready is always high.
//   Write configuration only while the block is idle.
// Sequencing:
//   When a velocity update is due, an accepted word passes through the prep
//   state, the multiply state, 28 steps of the serial restoring divider and
//   the commit state before out_valid rises. Without an update it goes from
//   prep straight to commit. A new word is accepted only once the previous
//   one has been committed to the result register.
// Reset: synchronous active-low; clears angle, tick, velocity and flags and
//   loads the configuration defaults (10 ms, 100 rpm).
// Receiver stall: the result word holds; the next word may be accepted and
//   processed, then waits at commit until the result register is taken.
`default_nettype none

module encoder_velocity_and_health_monitor_core #(
  parameter int COUNTS_PER_REV = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input words
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_outcome,
  input  wire logic [evhm_pkg::ANG_W-1:0]    in_angle,
  input  wire logic [evhm_pkg::SB_W-1:0]     in_status_byte,
  input  wire logic [evhm_pkg::TICK_W-1:0]   in_now_ms,
  // result words
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [evhm_pkg::VEL_W-1:0]  out_velocity_rpm,
  output logic                               out_ready_res,
  output logic                               out_hardware_fault,
  output logic                               out_magnet_missing,
  output logic                               out_magnet_weak,
  output logic                               out_magnet_strong,
  output logic                               out_spinning,
  output logic                               out_fan_fault,
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [evhm_pkg::CFGI_W-1:0]   cfg_index,
  input  wire logic [evhm_pkg::CFGD_W-1:0]   cfg_data
);

  evhm_pkg::cmd_t   cmd;
  evhm_pkg::sts_t   sts;
  evhm_pkg::flags_t flags;

  // configuration writes are always accepted
  assign cfg_ready = 1'b1;

  evhm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  evhm_dp #(
    .COUNTS_PER_REV (COUNTS_PER_REV)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_outcome     (in_outcome),
    .in_angle       (in_angle),
    .in_status_byte (in_status_byte),
    .in_now_ms      (in_now_ms),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .vel            (out_velocity_rpm),
    .flags          (flags)
  );

  // unpack the health flags onto the result word
  assign out_ready_res      = flags.ready;
  assign out_hardware_fault = flags.hw_fault;
  assign out_magnet_missing = flags.missing;
  assign out_magnet_weak    = flags.mag_low;
  assign out_magnet_strong  = flags.mag_high;
  assign out_spinning       = flags.spin;
  assign out_fan_fault      = flags.fan_fault;

endmodule

`default_nettype wire

[sim/evhm_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the encoder velocity and health monitor: watches the poll, result
// and register channels, predicts each result word and compares it field by field.
// Depends on evhm_pkg only.

module evhm_checker
  import evhm_pkg::*;
#(
  parameter int COUNTS_PER_REV = 4096
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic                    in_ready,
  input  wire logic [1:0]              in_outcome,
  input  wire logic [ANG_W-1:0]        in_angle,
  input  wire logic [SB_W-1:0]         in_status_byte,
  input  wire logic [TICK_W-1:0]       in_now_ms,
  input  wire logic                    out_valid,
  input  wire logic                    out_ready,
  input  wire logic signed [VEL_W-1:0] out_velocity_rpm,
  input  wire logic                    out_ready_res,
  input  wire logic                    out_hardware_fault,
  input  wire logic                    out_magnet_missing,
  input  wire logic                    out_magnet_weak,
  input  wire logic                    out_magnet_strong,
  input  wire logic                    out_spinning,
  input  wire logic                    out_fan_fault,
  input  wire logic                    cfg_valid,
  input  wire logic                    cfg_ready,
  input  wire logic [CFGI_W-1:0]       cfg_index,
  input  wire logic [CFGD_W-1:0]       cfg_data,
  output int                           n_fail,
  output int                           n_pending,
  output int                           n_checked,
  output int                           n_refresh
);

  typedef struct packed {
    logic signed [VEL_W-1:0] rpm;
    flags_t                  health;
  } health_word_t;

  // Shadow copy of the monitor's registers and state.
  logic [MINIV_W-1:0]      min_gap_ms;
  logic [THR_W-1:0]        spin_limit;
  logic [ANG_W-1:0]        last_angle;
  logic [TICK_W-1:0]       prior_tick;
  logic signed [VEL_W-1:0] cur_rpm;
  flags_t                  health;

  health_word_t awaited_words_q[$];
  health_word_t want_w;
  flags_t       seen_flags;

  // Indexed by bit position within flags_t.
  string flag_name [7] = '{"fan_fault", "spinning", "magnet_strong", "magnet_weak",
                           "magnet_missing", "hardware_fault", "ready_res"};

  task report_mismatch(input string what, input logic signed [31:0] got_v,
                       input logic signed [31:0] want_v);
    $display("MISMATCH word %0d: %s got %0d expected %0d", n_checked, what, got_v, want_v);
    n_fail++;
  endtask

  function void refresh_velocity(input logic [ANG_W-1:0] ang, input logic [TICK_W-1:0] now);
    logic [TICK_W-1:0] dt;
    logic [TICK_W-1:0] gap;
    int                a_new;
    int                a_old;
    int                delta;
    longint            mag;
    longint            q;
    dt = now - prior_tick;
    if (dt > DT_MAX) dt = TICK_W'(DT_MAX);
    gap = (min_gap_ms == '0) ? 1 : TICK_W'(min_gap_ms);
    if (dt < gap) return;
    a_new = int'(ang);
    a_old = int'(last_angle);
    delta = a_new - a_old;
    if (delta > COUNTS_PER_REV / 2) delta -= COUNTS_PER_REV;
    if (delta < -(COUNTS_PER_REV / 2)) delta += COUNTS_PER_REV;
    mag = (delta < 0) ? -delta : delta;
    q = (mag * 60000) / (longint'(dt) * COUNTS_PER_REV);
    if (q > RPM_LIMIT) q = RPM_LIMIT;
    cur_rpm = VEL_W'((delta < 0) ? -q : q);
    last_angle = ang;
    prior_tick = now;
    n_refresh++;
  endfunction

  function void take_status(input logic [SB_W-1:0] sb);
    flags_t h;
    int     r;
    int     lim;
    h = '0;
    h.ready = 1'b1;
    if (!sb[SB_MAGNET_BIT]) h.missing = 1'b1;
    else if (sb[SB_WEAK_BIT]) h.mag_low = 1'b1;
    else if (sb[SB_STRONG_BIT]) h.mag_high = 1'b1;
    r = cur_rpm;
    if (r < 0) r = -r;
    lim = int'(spin_limit);
    h.spin = (r > lim);
    h.fan_fault = h.missing | h.mag_low | h.mag_high;
    health = h;
  endfunction

  function health_word_t poll_outcome_word(input logic [1:0] oc, input logic [ANG_W-1:0] ang,
                                           input logic [SB_W-1:0] sb,
                                           input logic [TICK_W-1:0] now);
    case (oc)
      OUTC_ANGLE_FAIL: begin
        health.hw_fault = 1'b1;
        health.fan_fault = 1'b1;
      end
      OUTC_STATUS_FAIL: begin
        refresh_velocity(ang, now);
        health.hw_fault = 1'b1;
        health.fan_fault = 1'b1;
      end
      OUTC_GOOD: begin
        refresh_velocity(ang, now);
        take_status(sb);
      end
      default: ;  // unused code: hold everything
    endcase
    return '{rpm: cur_rpm, health: health};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      min_gap_ms = MIN_INTERVAL_RST;
      spin_limit = SPIN_THRESH_RST;
      last_angle = '0;
      prior_tick = '0;
      cur_rpm    = '0;
      health     = '0;
      awaited_words_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MIN_INTERVAL) min_gap_ms = cfg_data[MINIV_W-1:0];
        else if (cfg_index == CFG_SPIN_THRESH) spin_limit = cfg_data[THR_W-1:0];
      end
      // Retire before predicting so a word arriving with an empty queue is caught.
      if (out_valid && out_ready) begin
        seen_flags = {out_ready_res, out_hardware_fault, out_magnet_missing, out_magnet_weak,
                      out_magnet_strong, out_spinning, out_fan_fault};
        if (awaited_words_q.size() == 0) begin
          report_mismatch("result word with nothing awaited, velocity", out_velocity_rpm, 0);
        end else begin
          want_w = awaited_words_q.pop_front();
          if (out_velocity_rpm !== want_w.rpm)
            report_mismatch("velocity_rpm", out_velocity_rpm, want_w.rpm);
          for (int i = 0; i < 7; i++)
            if (seen_flags[i] !== want_w.health[i])
              report_mismatch(flag_name[i], seen_flags[i], want_w.health[i]);
        end
        n_checked++;
      end
      if (in_valid && in_ready)
        awaited_words_q.push_back(poll_outcome_word(in_outcome, in_angle, in_status_byte,
                                                    in_now_ms));
    end
    n_pending <= awaited_words_q.size();
  end

  initial begin
    n_fail = 0;
    n_checked = 0;
    n_refresh = 0;
    n_pending = 0;
  end

endmodule

[sim/encoder_velocity_and_health_monitor_core_tb.sv]
`timescale 1ns / 1ps
// Top of the encoder velocity and health monitor regression: clock, reset, poll and
// register stimulus, receiver back-pressure and the verdict.
// Depends on evhm_pkg, the core and evhm_checker.

module encoder_velocity_and_health_monitor_core_tb;
  import evhm_pkg::*;

  localparam int CPR         = 4096;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_POLLS = 113;
  localparam int TAIL_CYCLES = 40;   // longer than a full velocity refresh takes

  // Outcome code with no meaning; the block must emit its current values.
  localparam logic [1:0] OUTC_UNUSED = 2'd3;
  // Register indexes that decode to nothing.
  localparam logic [CFGI_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [CFGI_W-1:0] CFG_UNUSED_B = 2'd3;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              in_outcome;
  logic [ANG_W-1:0]        in_angle;
  logic [SB_W-1:0]         in_status_byte;
  logic [TICK_W-1:0]       in_now_ms;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [VEL_W-1:0] out_velocity_rpm;
  logic                    out_ready_res;
  logic                    out_hardware_fault;
  logic                    out_magnet_missing;
  logic                    out_magnet_weak;
  logic                    out_magnet_strong;
  logic                    out_spinning;
  logic                    out_fan_fault;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFGI_W-1:0]       cfg_index;
  logic [CFGD_W-1:0]       cfg_data;

  int n_fail;
  int n_pending;
  int n_checked;
  int n_refresh;

  // Idling knobs, in cycles out of a hundred.
  int idle_pct  = 0;
  int stall_pct = 0;

  // Stimulus bookkeeping: where the synthetic shaft and the tick have got to.
  logic [TICK_W-1:0] cur_tick;
  logic [ANG_W-1:0]  cur_ang;
  int                cur_gap_ms;
  int                polls_sent;
  int                directed_polls;
  int                settings_done;
  int                cycle_cnt;

  encoder_velocity_and_health_monitor_core #(
    .COUNTS_PER_REV(CPR)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_outcome         (in_outcome),
    .in_angle           (in_angle),
    .in_status_byte     (in_status_byte),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_velocity_rpm   (out_velocity_rpm),
    .out_ready_res      (out_ready_res),
    .out_hardware_fault (out_hardware_fault),
    .out_magnet_missing (out_magnet_missing),
    .out_magnet_weak    (out_magnet_weak),
    .out_magnet_strong  (out_magnet_strong),
    .out_spinning       (out_spinning),
    .out_fan_fault      (out_fan_fault),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  evhm_checker #(
    .COUNTS_PER_REV(CPR)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_outcome         (in_outcome),
    .in_angle           (in_angle),
    .in_status_byte     (in_status_byte),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_velocity_rpm   (out_velocity_rpm),
    .out_ready_res      (out_ready_res),
    .out_hardware_fault (out_hardware_fault),
    .out_magnet_missing (out_magnet_missing),
    .out_magnet_weak    (out_magnet_weak),
    .out_magnet_strong  (out_magnet_strong),
    .out_spinning       (out_spinning),
    .out_fan_fault      (out_fan_fault),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .n_fail             (n_fail),
    .n_pending          (n_pending),
    .n_checked          (n_checked),
    .n_refresh          (n_refresh)
  );

  // 10 ns clock, high then low.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: drop out_ready at random, at the rate the current phase asks for.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: give up well beyond the slowest legal run.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one poll word. Idle first at the sender's rate, then hold valid and
  // payload steady until the handshake. Valid is left high on return, so the
  // caller must either offer the next word or lower valid in the same step.
  task automatic send_poll(input logic [1:0] oc, input logic [ANG_W-1:0] ang,
                           input logic [SB_W-1:0] sb, input logic [TICK_W-1:0] now);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_outcome     <= oc;
    in_angle       <= ang;
    in_status_byte <= sb;
    in_now_ms      <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    polls_sent++;
  endtask

  // Drain the block, then write both limits. An unused index goes first with
  // random data; the block must shrug it off. Unused upper bits of the
  // interval word come in from the caller and must be ignored too.
  task automatic set_limits(input logic [CFGD_W-1:0] gap_word,
                            input logic [CFGD_W-1:0] thr_word);
    in_valid <= 1'b0;
    // Let the checker see the last accepted word before trusting its count.
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= $urandom_range(1) ? CFG_UNUSED_A : CFG_UNUSED_B;
    cfg_data  <= CFGD_W'($urandom_range(32767));
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_MIN_INTERVAL;
    cfg_data  <= gap_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_SPIN_THRESH;
    cfg_data  <= thr_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_gap_ms = (gap_word[MINIV_W-1:0] == '0) ? 1 : int'(gap_word[MINIV_W-1:0]);
    settings_done++;
  endtask

  // One random poll. Mostly plausible shaft motion sampled around the minimum
  // interval, with bus failures, the unused code, huge or backward tick jumps
  // and near half-revolution steps mixed in.
  task automatic random_poll();
    int               pick;
    int               d;
    logic [1:0]       oc;
    logic [ANG_W-1:0] ang;
    logic [SB_W-1:0]  sb;
    logic [TICK_W-1:0] now;
    pick = $urandom_range(99);
    if (pick < 70)      oc = OUTC_GOOD;
    else if (pick < 80) oc = OUTC_STATUS_FAIL;
    else if (pick < 90) oc = OUTC_ANGLE_FAIL;
    else                oc = OUTC_UNUSED;

    pick = $urandom_range(99);
    if (pick < 75)      now = cur_tick + $urandom_range(2 * cur_gap_ms + 3);
    else if (pick < 85) now = cur_tick + $urandom_range(cur_gap_ms);
    else if (pick < 92) now = cur_tick + $urandom_range(525000, 524000);
    else                now = $urandom();

    pick = $urandom_range(99);
    if (pick < 50)      d = $urandom_range(200) - 100;
    else if (pick < 65) d = 2048 + $urandom_range(2) - 1;
    else if (pick < 80) d = -2048 - $urandom_range(2) + 1;
    else                d = $urandom_range(4095);
    ang = cur_ang + d[ANG_W-1:0];

    if ($urandom_range(1)) begin
      sb = SB_W'($urandom_range(255));
    end else begin
      case ($urandom_range(6))
        0:       sb = 8'h00;
        1:       sb = 8'h20;
        2:       sb = 8'h28;
        3:       sb = 8'h30;
        4:       sb = 8'h38;
        5:       sb = 8'h10;
        default: sb = 8'h08;
      endcase
    end

    cur_tick = now;
    cur_ang  = ang;
    send_poll(oc, ang, sb, now);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_outcome     = OUTC_ANGLE_FAIL;
    in_angle       = '0;
    in_status_byte = '0;
    in_now_ms      = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_MIN_INTERVAL;
    cfg_data       = '0;
    polls_sent     = 0;
    settings_done  = 0;
    cur_gap_ms     = MIN_INTERVAL_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed walk under the reset limits (10 ms, 100 rpm), no idling.
    send_poll(OUTC_UNUSED,      12'hFFF, 8'hFF, 32'hFFFF_FFFF);  // ignored, all zero
    send_poll(OUTC_GOOD,        12'd0,    8'h20, 32'd5);   // inside the interval: no refresh
    send_poll(OUTC_GOOD,        12'd100,  8'h20, 32'd15);  // 97 rpm, just under threshold
    send_poll(OUTC_GOOD,        12'd2148, 8'h28, 32'd25);  // exactly +half rev, weak
    send_poll(OUTC_GOOD,        12'd99,   8'h38, 32'd35);  // -2049 wraps, weak beats strong
    send_poll(OUTC_GOOD,        12'd2147, 8'h30, 32'd45);  // exactly +half rev, strong
    send_poll(OUTC_GOOD,        12'd100,  8'h18, 32'd55);  // -2047, no wrap; no magnet wins
    send_poll(OUTC_ANGLE_FAIL,  12'hABC,  8'hFF, 32'd100); // bus failure, velocity held
    send_poll(OUTC_STATUS_FAIL, 12'd200,  8'h00, 32'd110); // refresh, then fault
    send_poll(OUTC_GOOD,        12'd300,  8'hE7, 32'd111); // too soon; faults clear
    send_poll(OUTC_STATUS_FAIL, 12'd400,  8'hFF, 32'd115); // too soon, fault again
    send_poll(OUTC_GOOD,        12'd2200, 8'h20, 32'h8000_0070); // elapsed time saturates
    send_poll(OUTC_GOOD,        12'hFFF,  8'h20, 32'hFFFF_FFF0);
    send_poll(OUTC_GOOD,        12'h000,  8'h20, 32'h0000_0005); // tick wraps past zero
    send_poll(OUTC_UNUSED,      12'h555,  8'h00, 32'h0000_0000);

    // Zero interval acts as one; threshold zero. Drive full-scale velocity.
    set_limits(15'd0, 15'd0);
    send_poll(OUTC_GOOD, 12'd2048, 8'h20, 32'd6);   // +30000 rpm
    send_poll(OUTC_GOOD, 12'd0,    8'h20, 32'd7);   // -30000 rpm
    send_poll(OUTC_GOOD, 12'd5,    8'h20, 32'd7);   // zero elapsed: hold velocity
    send_poll(OUTC_GOOD, 12'd0,    8'h20, 32'd9);   // standstill: spinning drops
    directed_polls = polls_sent;
    cur_tick = 32'd9;
    cur_ang  = 12'd0;

    // Phase one: no idling; interval 1 with junk in the unused upper bits.
    set_limits({5'h1F, 10'd1}, 15'd0);
    repeat (PHASE_POLLS) random_poll();

    // Phase two: sender mostly idle; long interval, threshold at full-scale velocity.
    idle_pct = 83;
    set_limits(15'd1000, 15'd30000);
    repeat (PHASE_POLLS) random_poll();

    // Phase three: receiver mostly stalled; threshold beyond any velocity.
    idle_pct  = 0;
    stall_pct = 83;
    set_limits({5'($urandom_range(31)), 10'($urandom_range(50, 2))}, 15'h7FFF);
    repeat (PHASE_POLLS) random_poll();

    // Phase four: light idling on both sides, short interval, low threshold.
    idle_pct  = 21;
    stall_pct = 21;
    set_limits({5'd0, 10'($urandom_range(12, 1))}, 15'($urandom_range(3000)));
    repeat (PHASE_POLLS) random_poll();

    // Drain: hold valid low, wait for every awaited word, then watch for strays.
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d polls (%0d directed) and %0d result words, %0d velocity refreshes",
             polls_sent, directed_polls, n_checked, n_refresh);
    $display("across %0d limit settings and four idling mixes; %0d mismatches",
             settings_done, n_fail);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
